>>> sv/mhq_pkg.sv
`default_nettype none
package mhq_pkg;

	// store geometry
	localparam int MAX_VERTICES = 4096;
	localparam int MAX_FACES    = 4096;
	localparam int COORD_BITS   = 24;

	localparam int VADDR_W = $clog2(MAX_VERTICES);
	localparam int FADDR_W = $clog2(MAX_FACES);
	localparam int SLOT_W  = 12;
	localparam int IDX_W   = 12;
	localparam int FCNT_W  = 13;
	localparam int WIN_W   = 23;

	// arithmetic widths
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int MUL_W   = DIFF_W + 1;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int NRM_W   = 2 * DIFF_W + 1;
	localparam int SPLIT   = DIFF_W;
	localparam int ACC_W   = PROD_W + SPLIT + 1;
	localparam int HGT_W   = ACC_W + 1;
	localparam int DCNT_W  = $clog2(ACC_W + 1);
	localparam int TERM_W  = 4;
	localparam int KCNT_W  = TERM_W + 1;

	// stream packing
	localparam int OFF_X     = SLOT_W;
	localparam int OFF_Y     = OFF_X + COORD_BITS;
	localparam int OFF_Z     = OFF_Y + COORD_BITS;
	localparam int OFF_A     = OFF_Z + COORD_BITS;
	localparam int OFF_B     = OFF_A + IDX_W;
	localparam int OFF_C     = OFF_B + IDX_W;
	localparam int S_TDATA_W = ((OFF_C + IDX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((COORD_BITS + FADDR_W + 7) / 8) * 8;

	// apb
	localparam int PADDR_W = 3;
	localparam int APB_W   = 32;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(25600);
	localparam logic [FCNT_W-1:0] FACE_LIMIT  = FCNT_W'(MAX_FACES);
	localparam int ONE_Q8 = 256;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [MUL_W-1:0]      mop_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [NRM_W-1:0]      nrm_t;
	typedef logic signed [ACC_W-1:0]      acc_t;
	typedef logic signed [HGT_W-1:0]      hgt_t;
	typedef logic [S_TDATA_W-1:0]         sdata_t;
	typedef logic [M_TDATA_W-1:0]         mdata_t;
	typedef logic [APB_W-1:0]             apb_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_VERTEX = 2'd0,
		KIND_FACE   = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		REG_FACE_COUNT    = 1'b0,
		REG_HEIGHT_WINDOW = 1'b1
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FACE,
		ST_CORNA,
		ST_CORNB,
		ST_CORNC,
		ST_VTX2,
		ST_MATH,
		ST_DIV,
		ST_HGT,
		ST_CHK,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		DST_CROSS,
		DST_NY,
		DST_NX,
		DST_NZ,
		DST_NUM
	} dest_t;

	typedef struct packed {
		logic  first;
		logic  last;
		logic  sub;
		logic  shift;
		dest_t dest;
	} term_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} vec_t;

	typedef struct packed {
		diff_t z;
		diff_t y;
		diff_t x;
	} dvec_t;

	typedef struct packed {
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] a;
	} face_t;

	typedef struct packed {
		logic               found;
		coord_t             height;
		logic [FADDR_W-1:0] face;
	} result_t;

	function automatic dvec_t vdiff(input vec_t u, input vec_t w);
		dvec_t r;
		r.x = diff_t'(u.x) - diff_t'(w.x);
		r.y = diff_t'(u.y) - diff_t'(w.y);
		r.z = diff_t'(u.z) - diff_t'(w.z);
		return r;
	endfunction

	// micro-sequence: cross tests, normal y, x, z, then the plane numerator
	function automatic term_t mhq_term(input logic [TERM_W-1:0] k);
		term_t t;
		t.first = (k < 4'd12) ? !k[0] : (k == 4'd12);
		t.last  = (k < 4'd12) ? k[0] : (k == 4'd15);
		t.sub   = (k < 4'd12) && k[0];
		t.shift = (k >= 4'd12) && k[0];
		case (k) inside
			[4'd0:4'd5]:   t.dest = DST_CROSS;
			[4'd6:4'd7]:   t.dest = DST_NY;
			[4'd8:4'd9]:   t.dest = DST_NX;
			[4'd10:4'd11]: t.dest = DST_NZ;
			default:       t.dest = DST_NUM;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

>>> sv/mesh_height_query.sv
// mesh_height_query: ground height lookup on a stored triangle mesh
//
// input stream (s_*): one beat per item, kind in s_tuser
//   vertex load writes slot in the vertex memory, face load writes corner
//   indices in the face memory; both give no result
//   a query walks faces 0 .. min(face_count, 4096)-1 until a hit; one result beat
// output stream (m_*): m_tuser is found, m_tdata holds height and face index
// configuration: apb port, face_count at 0x0, height_window at 0x4
//
// a query reads, per face tested, the face and its corners from memory, then
// runs multiply-accumulate steps on one 26x26 multiplier (a face failing an
// edge test or with a zero normal y leaves early); each face that reaches the
// plane height then goes through a bit-serial divide, height, and window check
// one item is worked on at a time; loads are taken in back to back cycles
// a finished result sits in an output register, so a stalled m_tready holds
// only the next query's final beat, not the walk itself
// reset clears control and face_count, presets height_window; memory is undefined until loaded
`default_nettype none
module mesh_height_query (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [mhq_pkg::S_TDATA_W-1:0]   s_tdata,
	// s_tuser: kind
	input  wire logic [1:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// m_tdata: ground_height, hit_face, zero fill
	output logic      [mhq_pkg::M_TDATA_W-1:0]   m_tdata,
	// m_tuser: found
	output logic                                 m_tuser,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [mhq_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [mhq_pkg::APB_W-1:0]       pwdata,
	output logic      [mhq_pkg::APB_W-1:0]       prdata,
	output logic                                 pready
);

	logic [mhq_pkg::FCNT_W-1:0] face_count_q;
	logic [mhq_pkg::WIN_W-1:0]  window_q;
	logic                       cfg_wr;
	mhq_pkg::reg_t              reg_sel;

	logic                       in_beat;
	mhq_pkg::kind_t             kind;
	mhq_pkg::vec_t              point;
	mhq_pkg::face_t             face_in;
	logic [mhq_pkg::SLOT_W-1:0] slot;

	logic [mhq_pkg::FADDR_W-1:0] face_raddr;
	logic [mhq_pkg::VADDR_W-1:0] vtx_raddr;
	mhq_pkg::face_t              face_rdata;
	mhq_pkg::vec_t               vtx_rdata;
	logic                        eng_idle;
	mhq_pkg::result_t            res;

	// apb registers, always ready
	assign pready  = 1'b1;
	assign reg_sel = mhq_pkg::reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_count_q <= '0;
			window_q     <= mhq_pkg::WINDOW_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				mhq_pkg::REG_FACE_COUNT:    face_count_q <= pwdata[mhq_pkg::FCNT_W-1:0];
				mhq_pkg::REG_HEIGHT_WINDOW: window_q     <= pwdata[mhq_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			mhq_pkg::REG_FACE_COUNT:    prdata = mhq_pkg::apb_t'(face_count_q);
			mhq_pkg::REG_HEIGHT_WINDOW: prdata = mhq_pkg::apb_t'(window_q);
			default:                    prdata = '0;
		endcase
	end

	// input beat unpacking
	assign kind      = mhq_pkg::kind_t'(s_tuser);
	assign slot      = s_tdata[mhq_pkg::SLOT_W-1:0];
	assign point.x   = s_tdata[mhq_pkg::OFF_X +: mhq_pkg::COORD_BITS];
	assign point.y   = s_tdata[mhq_pkg::OFF_Y +: mhq_pkg::COORD_BITS];
	assign point.z   = s_tdata[mhq_pkg::OFF_Z +: mhq_pkg::COORD_BITS];
	assign face_in.a = s_tdata[mhq_pkg::OFF_A +: mhq_pkg::IDX_W];
	assign face_in.b = s_tdata[mhq_pkg::OFF_B +: mhq_pkg::IDX_W];
	assign face_in.c = s_tdata[mhq_pkg::OFF_C +: mhq_pkg::IDX_W];

	// loads and queries are only taken while the walk engine is idle
	assign s_tready = eng_idle;
	assign in_beat  = s_tvalid && s_tready;

	// vertex store: x lowest, then y, z
	mhq_ram #(
		.WIDTH ($bits(mhq_pkg::vec_t)),
		.DEPTH (mhq_pkg::MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (in_beat && kind == mhq_pkg::KIND_VERTEX),
		.waddr (slot[mhq_pkg::VADDR_W-1:0]),
		.wdata (point),
		.raddr (vtx_raddr),
		.rdata (vtx_rdata)
	);

	// face store: corner a lowest
	mhq_ram #(
		.WIDTH ($bits(mhq_pkg::face_t)),
		.DEPTH (mhq_pkg::MAX_FACES)
	) u_face_ram (
		.clk   (clk),
		.we    (in_beat && kind == mhq_pkg::KIND_FACE),
		.waddr (slot[mhq_pkg::FADDR_W-1:0]),
		.wdata (face_in),
		.raddr (face_raddr),
		.rdata (face_rdata)
	);

	mhq_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_beat && kind == mhq_pkg::KIND_QUERY),
		.point         (point),
		.face_count    (face_count_q),
		.height_window (window_q),
		.face_raddr    (face_raddr),
		.face_rdata    (face_rdata),
		.vtx_raddr     (vtx_raddr),
		.vtx_rdata     (vtx_rdata),
		.idle          (eng_idle),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res           (res)
	);

	assign m_tuser = res.found;
	assign m_tdata = mhq_pkg::mdata_t'({res.face, res.height});

`ifndef SYNTHESIS
	// a query occupies the engine, so the next beat waits
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && kind == mhq_pkg::KIND_QUERY) |=> !s_tready)
		else $error("input taken right after a query");

	// a miss carries zero height and zero face index
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("miss result with nonzero payload");

	// window register follows the apb write
	a_window_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_sel == mhq_pkg::REG_HEIGHT_WINDOW)
		|=> (window_q == $past(pwdata[mhq_pkg::WIN_W-1:0])))
		else $error("height window not written");
`endif

endmodule
`default_nettype wire

>>> sv/mhq_ram.sv
`default_nettype none
module mhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> sv/mhq_div.sv
`default_nettype none
module mhq_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire mhq_pkg::acc_t num,
	input  wire mhq_pkg::nrm_t den,
	output logic               done,
	output mhq_pkg::acc_t      quo
);

	logic                          busy_q;
	logic                          done_q;
	logic [mhq_pkg::DCNT_W-1:0]    cnt_q;
	logic [mhq_pkg::ACC_W-1:0]     n_q;
	logic [mhq_pkg::ACC_W-1:0]     q_q;
	logic [mhq_pkg::NRM_W-1:0]     d_q;
	logic [mhq_pkg::NRM_W:0]       r_q;
	logic                          neg_q;
	logic [mhq_pkg::NRM_W:0]       r_sh;
	logic                          ge;

	// restoring division on magnitudes, one quotient bit a cycle
	assign r_sh = {r_q[mhq_pkg::NRM_W-1:0], n_q[mhq_pkg::ACC_W-1]};
	assign ge   = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mhq_pkg::DCNT_W'(mhq_pkg::ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mhq_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[mhq_pkg::ACC_W-1] ? -num : num;
			d_q   <= den[mhq_pkg::NRM_W-1] ? -den : den;
			r_q   <= '0;
			q_q   <= '0;
			neg_q <= num[mhq_pkg::ACC_W-1] ^ den[mhq_pkg::NRM_W-1];
		end else if (busy_q) begin
			n_q <= {n_q[mhq_pkg::ACC_W-2:0], 1'b0};
			q_q <= {q_q[mhq_pkg::ACC_W-2:0], ge};
			r_q <= ge ? r_sh - {1'b0, d_q} : r_sh;
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? mhq_pkg::acc_t'(-q_q) : mhq_pkg::acc_t'(q_q);

endmodule
`default_nettype wire

>>> sv/mhq_engine.sv
`default_nettype none
module mhq_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire mhq_pkg::vec_t                point,
	input  wire logic [mhq_pkg::FCNT_W-1:0]   face_count,
	input  wire logic [mhq_pkg::WIN_W-1:0]    height_window,
	output logic      [mhq_pkg::FADDR_W-1:0]  face_raddr,
	input  wire mhq_pkg::face_t               face_rdata,
	output logic      [mhq_pkg::VADDR_W-1:0]  vtx_raddr,
	input  wire mhq_pkg::vec_t                vtx_rdata,
	output logic                              idle,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output mhq_pkg::result_t                  res
);

	mhq_pkg::state_t state_q, state_d;

	logic [mhq_pkg::FCNT_W-1:0] f_q, nf_q, nf_in;
	logic [mhq_pkg::IDX_W-1:0]  cb_q, cc_q;
	logic [mhq_pkg::KCNT_W-1:0] k_q;
	mhq_pkg::vec_t    p_q, v0_q, v1_q, v2_q;
	mhq_pkg::prod_t   prod_s1;
	mhq_pkg::term_t   term_s1;
	logic             valid_s1;
	mhq_pkg::acc_t    acc_q, acc_next, pe;
	mhq_pkg::nrm_t    ny_q, nx_q, nz_q;
	mhq_pkg::hgt_t    h_q, py_h, win_h, res_h;
	mhq_pkg::coord_t  sat_q, sat;
	logic             hit_q, res_valid_q;
	mhq_pkg::result_t res_q;
	mhq_pkg::dvec_t   da, db, de1, de2, dp0, dp1, dp2;
	mhq_pkg::mop_t    op_a, op_b;
	mhq_pkg::acc_t    quo;
	logic             div_done, div_start;
	logic             issue, grp_end, reject, num_done, advance, in_win;

	assign nf_in = (face_count > mhq_pkg::FACE_LIMIT) ? mhq_pkg::FACE_LIMIT : face_count;

	assign da  = mhq_pkg::vdiff(v0_q, v2_q);
	assign db  = mhq_pkg::vdiff(v1_q, v2_q);
	assign de1 = mhq_pkg::vdiff(v1_q, v0_q);
	assign de2 = mhq_pkg::vdiff(v2_q, v1_q);
	assign dp0 = mhq_pkg::vdiff(p_q, v0_q);
	assign dp1 = mhq_pkg::vdiff(p_q, v1_q);
	assign dp2 = mhq_pkg::vdiff(p_q, v2_q);

	// operand select for the shared multiplier
	always_comb begin
		case (k_q[mhq_pkg::TERM_W-1:0])
			4'd0:    begin op_a = mhq_pkg::mop_t'(da.z);  op_b = mhq_pkg::mop_t'(dp2.x); end
			4'd1:    begin op_a = mhq_pkg::mop_t'(da.x);  op_b = mhq_pkg::mop_t'(dp2.z); end
			4'd2:    begin op_a = mhq_pkg::mop_t'(de1.z); op_b = mhq_pkg::mop_t'(dp0.x); end
			4'd3:    begin op_a = mhq_pkg::mop_t'(de1.x); op_b = mhq_pkg::mop_t'(dp0.z); end
			4'd4:    begin op_a = mhq_pkg::mop_t'(de2.z); op_b = mhq_pkg::mop_t'(dp1.x); end
			4'd5:    begin op_a = mhq_pkg::mop_t'(de2.x); op_b = mhq_pkg::mop_t'(dp1.z); end
			4'd6:    begin op_a = mhq_pkg::mop_t'(da.z);  op_b = mhq_pkg::mop_t'(db.x);  end
			4'd7:    begin op_a = mhq_pkg::mop_t'(da.x);  op_b = mhq_pkg::mop_t'(db.z);  end
			4'd8:    begin op_a = mhq_pkg::mop_t'(da.y);  op_b = mhq_pkg::mop_t'(db.z);  end
			4'd9:    begin op_a = mhq_pkg::mop_t'(da.z);  op_b = mhq_pkg::mop_t'(db.y);  end
			4'd10:   begin op_a = mhq_pkg::mop_t'(da.x);  op_b = mhq_pkg::mop_t'(db.y);  end
			4'd11:   begin op_a = mhq_pkg::mop_t'(da.y);  op_b = mhq_pkg::mop_t'(db.x);  end
			4'd12: begin
				op_a = mhq_pkg::mop_t'(dp2.x);
				op_b = mhq_pkg::mop_t'({1'b0, nx_q[mhq_pkg::SPLIT-1:0]});
			end
			4'd13: begin
				op_a = mhq_pkg::mop_t'(dp2.x);
				op_b = mhq_pkg::mop_t'(nx_q[mhq_pkg::NRM_W-1:mhq_pkg::SPLIT]);
			end
			4'd14: begin
				op_a = mhq_pkg::mop_t'(dp2.z);
				op_b = mhq_pkg::mop_t'({1'b0, nz_q[mhq_pkg::SPLIT-1:0]});
			end
			default: begin
				op_a = mhq_pkg::mop_t'(dp2.z);
				op_b = mhq_pkg::mop_t'(nz_q[mhq_pkg::NRM_W-1:mhq_pkg::SPLIT]);
			end
		endcase
	end

	// accumulate the product issued in the previous cycle
	assign pe = term_s1.shift ? (mhq_pkg::acc_t'(prod_s1) <<< mhq_pkg::SPLIT)
		: mhq_pkg::acc_t'(prod_s1);
	assign acc_next = (term_s1.first ? mhq_pkg::acc_t'(0) : acc_q) + (term_s1.sub ? -pe : pe);

	assign issue    = (state_q == mhq_pkg::ST_MATH) && !k_q[mhq_pkg::TERM_W];
	assign grp_end  = (state_q == mhq_pkg::ST_MATH) && valid_s1 && term_s1.last;
	assign reject   = grp_end && (((term_s1.dest == mhq_pkg::DST_CROSS) && acc_next[mhq_pkg::ACC_W-1])
		|| ((term_s1.dest == mhq_pkg::DST_NY) && (acc_next == '0)));
	assign num_done = grp_end && (term_s1.dest == mhq_pkg::DST_NUM);
	assign div_start = num_done;

	// window test and saturation of the hit height
	assign py_h  = mhq_pkg::hgt_t'(p_q.y);
	assign win_h = mhq_pkg::hgt_t'({1'b0, height_window});
	assign in_win = !(py_h < h_q - win_h) && !(h_q + win_h < py_h);
	assign res_h = h_q + mhq_pkg::hgt_t'(mhq_pkg::ONE_Q8);

	always_comb begin
		if (res_h > mhq_pkg::hgt_t'(mhq_pkg::COORD_MAX)) begin
			sat = mhq_pkg::COORD_MAX;
		end else if (res_h < mhq_pkg::hgt_t'(mhq_pkg::COORD_MIN)) begin
			sat = mhq_pkg::COORD_MIN;
		end else begin
			sat = mhq_pkg::coord_t'(res_h);
		end
	end

	mhq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_next),
		.den    (ny_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		face_raddr = f_q[mhq_pkg::FADDR_W-1:0];
		vtx_raddr  = face_rdata.a;
		advance    = 1'b0;
		unique case (state_q)
			mhq_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (nf_in == '0) ? mhq_pkg::ST_DONE : mhq_pkg::ST_FACE;
				end
			end
			mhq_pkg::ST_FACE:  state_d = mhq_pkg::ST_CORNA;
			mhq_pkg::ST_CORNA: state_d = mhq_pkg::ST_CORNB;
			mhq_pkg::ST_CORNB: begin
				vtx_raddr = cb_q;
				state_d   = mhq_pkg::ST_CORNC;
			end
			mhq_pkg::ST_CORNC: begin
				vtx_raddr = cc_q;
				state_d   = mhq_pkg::ST_VTX2;
			end
			mhq_pkg::ST_VTX2: state_d = mhq_pkg::ST_MATH;
			mhq_pkg::ST_MATH: begin
				if (reject) begin
					advance = 1'b1;
				end else if (num_done) begin
					state_d = mhq_pkg::ST_DIV;
				end
			end
			mhq_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = mhq_pkg::ST_HGT;
				end
			end
			mhq_pkg::ST_HGT: state_d = mhq_pkg::ST_CHK;
			mhq_pkg::ST_CHK: begin
				if (in_win) begin
					state_d = mhq_pkg::ST_DONE;
				end else begin
					advance = 1'b1;
				end
			end
			mhq_pkg::ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					state_d = mhq_pkg::ST_IDLE;
				end
			end
			default: state_d = mhq_pkg::ST_IDLE;
		endcase
		if (advance) begin
			state_d = (f_q + 1'b1 == nf_q) ? mhq_pkg::ST_DONE : mhq_pkg::ST_FACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hit_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (state_q == mhq_pkg::ST_IDLE && start) begin
				hit_q <= 1'b0;
			end else if (state_q == mhq_pkg::ST_CHK && in_win) begin
				hit_q <= 1'b1;
			end
			if (state_q == mhq_pkg::ST_DONE && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mhq_pkg::ST_IDLE && start) begin
			p_q  <= point;
			nf_q <= nf_in;
			f_q  <= '0;
		end
		if (advance) begin
			f_q <= f_q + 1'b1;
		end
		if (state_q == mhq_pkg::ST_CORNA) begin
			cb_q <= face_rdata.b;
			cc_q <= face_rdata.c;
		end
		if (state_q == mhq_pkg::ST_CORNB) begin
			v0_q <= vtx_rdata;
		end
		if (state_q == mhq_pkg::ST_CORNC) begin
			v1_q <= vtx_rdata;
		end
		if (state_q == mhq_pkg::ST_VTX2) begin
			v2_q <= vtx_rdata;
			k_q  <= '0;
		end else if (issue) begin
			k_q <= k_q + 1'b1;
		end
		prod_s1 <= mhq_pkg::prod_t'(op_a * op_b);
		term_s1 <= mhq_pkg::mhq_term(k_q[mhq_pkg::TERM_W-1:0]);
		if (state_q == mhq_pkg::ST_MATH && valid_s1) begin
			acc_q <= acc_next;
		end
		if (grp_end && term_s1.dest == mhq_pkg::DST_NY) begin
			ny_q <= mhq_pkg::nrm_t'(acc_next);
		end
		if (grp_end && term_s1.dest == mhq_pkg::DST_NX) begin
			nx_q <= mhq_pkg::nrm_t'(acc_next);
		end
		if (grp_end && term_s1.dest == mhq_pkg::DST_NZ) begin
			nz_q <= mhq_pkg::nrm_t'(acc_next);
		end
		if (state_q == mhq_pkg::ST_HGT) begin
			h_q <= mhq_pkg::hgt_t'(v2_q.y) - mhq_pkg::hgt_t'(quo);
		end
		if (state_q == mhq_pkg::ST_CHK) begin
			sat_q <= sat;
		end
		if (state_q == mhq_pkg::ST_DONE && (!res_valid_q || res_ready)) begin
			res_q.found  <= hit_q;
			res_q.height <= hit_q ? sat_q : mhq_pkg::coord_t'(0);
			res_q.face   <= hit_q ? f_q[mhq_pkg::FADDR_W-1:0] : '0;
		end
	end

	assign idle      = (state_q == mhq_pkg::ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

>>> tb/mhq_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module mhq_checker
	import mhq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [1:0]           s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [M_TDATA_W-1:0] m_tdata,
	input  wire logic                 m_tuser,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [PADDR_W-1:0]   paddr,
	input  wire logic [APB_W-1:0]     pwdata,
	input  wire logic                 pready,
	output int                        errors,
	output int                        pending
);

	typedef logic signed [127:0] wide_t;

	coord_t           vtx_x [MAX_VERTICES];
	coord_t           vtx_y [MAX_VERTICES];
	coord_t           vtx_z [MAX_VERTICES];
	face_t            faces [MAX_FACES];
	logic [FCNT_W-1:0] face_count;
	logic [WIN_W-1:0]  height_window;
	result_t          heights_due [$];

	assign pending = heights_due.size();

	// y component of edge x offset
	function automatic wide_t edge_side(input wide_t ex, input wide_t ez,
			input wide_t dx, input wide_t dz);
		return ez * dx - ex * dz;
	endfunction

	function automatic result_t ground_lookup(input coord_t px, input coord_t py,
			input coord_t pz);
		result_t r;
		int nf;
		face_t fc;
		wide_t x0, y0, z0, x1, y1, z1, x2, y2, z2, ax, ay, az, bx, by, bz;
		wide_t nx, ny, nz, num, h, win, res, qx, qy, qz;
		r = '0;
		nf = (face_count > FACE_LIMIT) ? MAX_FACES : int'(face_count);
		qx = wide_t'(px);
		qy = wide_t'(py);
		qz = wide_t'(pz);
		win = wide_t'(height_window);
		for (int f = 0; f < nf; f++) begin
			fc = faces[f];
			x0 = wide_t'(vtx_x[fc.a]); y0 = wide_t'(vtx_y[fc.a]); z0 = wide_t'(vtx_z[fc.a]);
			x1 = wide_t'(vtx_x[fc.b]); y1 = wide_t'(vtx_y[fc.b]); z1 = wide_t'(vtx_z[fc.b]);
			x2 = wide_t'(vtx_x[fc.c]); y2 = wide_t'(vtx_y[fc.c]); z2 = wide_t'(vtx_z[fc.c]);
			ax = x0 - x2; ay = y0 - y2; az = z0 - z2;
			bx = x1 - x2; by = y1 - y2; bz = z1 - z2;
			if (edge_side(ax, az, qx - x2, qz - z2) < 0) continue;
			if (edge_side(x1 - x0, z1 - z0, qx - x0, qz - z0) < 0) continue;
			if (edge_side(x2 - x1, z2 - z1, qx - x1, qz - z1) < 0) continue;
			nx = ay * bz - az * by;
			ny = az * bx - ax * bz;
			nz = ax * by - ay * bx;
			// flat normal: plane is vertical in xz, skip it
			if (ny == 0) continue;
			num = (qx - x2) * nx + (qz - z2) * nz;
			h = y2 - num / ny;
			if (qy < h - win || qy > h + win) continue;
			res = h + ONE_Q8;
			if (res > wide_t'(COORD_MAX)) res = wide_t'(COORD_MAX);
			if (res < wide_t'(COORD_MIN)) res = wide_t'(COORD_MIN);
			r.found = 1'b1;
			r.height = coord_t'(res);
			r.face = FADDR_W'(f);
			return r;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		face_t fc;
		if (!arst_n) begin
			face_count = '0;
			height_window = WINDOW_RESET;
			heights_due.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_FACE_COUNT) face_count = pwdata[FCNT_W-1:0];
				else height_window = pwdata[WIN_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.height = m_tdata[COORD_BITS-1:0];
				got.face = m_tdata[COORD_BITS +: FADDR_W];
				if (heights_due.size() == 0) begin
					$error("result beat with nothing expected: found %0d height %0d face %0d",
						got.found, got.height, got.face);
					errors++;
				end else begin
					want = heights_due.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d actual %0d", want.found, got.found);
						errors++;
					end
					if (got.height !== want.height) begin
						$error("ground_height: expected %0d actual %0d", want.height, got.height);
						errors++;
					end
					if (got.face !== want.face) begin
						$error("hit_face: expected %0d actual %0d", want.face, got.face);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (kind_t'(s_tuser))
					KIND_VERTEX: begin
						vtx_x[s_tdata[SLOT_W-1:0]] = s_tdata[OFF_X +: COORD_BITS];
						vtx_y[s_tdata[SLOT_W-1:0]] = s_tdata[OFF_Y +: COORD_BITS];
						vtx_z[s_tdata[SLOT_W-1:0]] = s_tdata[OFF_Z +: COORD_BITS];
					end
					KIND_FACE: begin
						fc.a = s_tdata[OFF_A +: IDX_W];
						fc.b = s_tdata[OFF_B +: IDX_W];
						fc.c = s_tdata[OFF_C +: IDX_W];
						faces[s_tdata[SLOT_W-1:0]] = fc;
					end
					KIND_QUERY: heights_due.push_back(ground_lookup(
						s_tdata[OFF_X +: COORD_BITS], s_tdata[OFF_Y +: COORD_BITS],
						s_tdata[OFF_Z +: COORD_BITS]));
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import mhq_pkg::*;

	// idle cycles with no beat on any port before giving up
	localparam int STALL_LIMIT = 2000000;
	localparam int PRESSURE_HOLD = 5000;
	localparam int SETTLE = 60;
	localparam coord_t SIDE = coord_t'(25600);     // 100.0 in Q16.8
	localparam coord_t FLOOR_Y = coord_t'(1280);
	localparam int MESH_VERTS = 16;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
	logic [1:0]           s_tuser;   // kind
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // ground_height, hit_face, zero fill
	logic                 m_tuser;   // found
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [APB_W-1:0]     pwdata;
	logic [APB_W-1:0]     prdata;
	logic                 pready;
	int                   errors;
	int                   pending;

	// shared between the stimulus and the output-side stall process
	bit                   steady;    // no idling on either side
	bit                   hold_req;  // ask the receiver for one long hold-off
	int                   quiet_cycles;

	mesh_height_query u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mhq_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// none when steady; else mostly back to back, sometimes a short gap, rarely a long pause
	function automatic int idle_len();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic coord_t near(input int span);
		return coord_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// one input beat; s_tvalid stays high into the next beat when no gap falls
	task automatic send(input kind_t k, input logic [SLOT_W-1:0] slot,
			input coord_t x, input coord_t y, input coord_t z,
			input logic [IDX_W-1:0] ca, input logic [IDX_W-1:0] cb,
			input logic [IDX_W-1:0] cc);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= S_TDATA_W'({cc, cb, ca, z, y, x, slot});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic vertex(input logic [SLOT_W-1:0] slot, input coord_t x,
			input coord_t y, input coord_t z);
		send(KIND_VERTEX, slot, x, y, z, IDX_W'($urandom), IDX_W'($urandom),
			IDX_W'($urandom));
	endtask

	task automatic face(input logic [SLOT_W-1:0] slot, input logic [IDX_W-1:0] ca,
			input logic [IDX_W-1:0] cb, input logic [IDX_W-1:0] cc);
		send(KIND_FACE, slot, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), ca, cb, cc);
	endtask

	task automatic query(input coord_t x, input coord_t y, input coord_t z);
		send(KIND_QUERY, SLOT_W'($urandom), x, y, z, IDX_W'($urandom),
			IDX_W'($urandom), IDX_W'($urandom));
	endtask

	// drop valid, wait for every result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write: setup then access; pready is always high
	task automatic reg_write(input reg_t idx, input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// random mix: mesh vertices 0 .. MESH_VERTS-1, far vertices, faces, kind-none beats, queries mostly near the mesh
	task automatic random_phase(input int n, input int fc_max);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				vertex(SLOT_W'($urandom_range(0, MESH_VERTS - 1)), near(51200),
					near(51200), near(51200));
			else if (r < 25)
				// far slots lie above the mesh vertices; no face that is walked points there
				vertex(SLOT_W'($urandom_range(MESH_VERTS, MAX_VERTICES - 1)),
					coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
			else if (r < 38)
				face(SLOT_W'($urandom_range(0, fc_max - 1)),
					IDX_W'($urandom_range(0, MESH_VERTS - 1)),
					IDX_W'($urandom_range(0, MESH_VERTS - 1)),
					IDX_W'($urandom_range(0, MESH_VERTS - 1)));
			else if (r < 42)
				send(KIND_NONE, SLOT_W'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), IDX_W'($urandom), IDX_W'($urandom),
					IDX_W'($urandom));
			else if (r < 88)
				query(near(51200), near(60000), near(51200));
			else
				query(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = PRESSURE_HOLD;
				m_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				hold_left = idle_len();
				m_tready <= (hold_left == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog: cycles without any beat on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("mesh_height_query verification failed");
			$finish;
		end
	end

	initial begin
		quiet_cycles = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_VERTEX;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// no faces searched: not found
		reg_write(REG_FACE_COUNT, 0);
		query(24'sd0, FLOOR_Y, 24'sd0);
		// flat square at FLOOR_Y, both windings, with a degenerate face first
		vertex(12'd0, -SIDE, FLOOR_Y, -SIDE);
		vertex(12'd1, SIDE, FLOOR_Y, -SIDE);
		vertex(12'd2, SIDE, FLOOR_Y, SIDE);
		vertex(12'd3, -SIDE, FLOOR_Y, SIDE);
		vertex(12'd5, 24'sd0, 24'sd500, 24'sd0);
		// triangle at the top of the range: result saturates
		vertex(12'd6, -SIDE, COORD_MAX, -SIDE);
		vertex(12'd7, SIDE, COORD_MAX, -SIDE);
		vertex(12'd8, SIDE, COORD_MAX, SIDE);
		vertex(12'd4095, COORD_MAX, COORD_MIN, COORD_MAX);
		face(12'd0, 12'd5, 12'd5, 12'd5);      // collinear corners: zero normal y, skipped
		face(12'd1, 12'd0, 12'd1, 12'd2);
		face(12'd2, 12'd0, 12'd2, 12'd1);
		face(12'd3, 12'd0, 12'd2, 12'd3);
		face(12'd4, 12'd0, 12'd3, 12'd2);
		face(12'd5, 12'd6, 12'd7, 12'd8);
		face(12'd6, 12'd6, 12'd8, 12'd7);
		face(12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send(KIND_NONE, 12'hfff, COORD_MIN, COORD_MAX, COORD_MIN, 12'hfff, 12'hfff, 12'hfff);
		drain();
		reg_write(REG_FACE_COUNT, 7);
		query(24'sd0, FLOOR_Y, 24'sd0);                        // degenerate skipped, square hit
		query(24'sd100, FLOOR_Y + SIDE, -24'sd200);            // window edge, still inside
		query(24'sd100, FLOOR_Y + SIDE + 24'sd1, -24'sd200);   // just outside the window
		query(SIDE, FLOOR_Y, SIDE);                            // on a corner
		query(coord_t'(2 * SIDE), FLOOR_Y, 24'sd0);            // outside the mesh in xz
		query(coord_t'(SIDE / 2), COORD_MAX, coord_t'(-SIDE / 2)); // saturated height
		query(COORD_MIN, 24'sd0, COORD_MAX);
		drain();
		reg_write(REG_HEIGHT_WINDOW, 0);
		query(24'sd300, FLOOR_Y, 24'sd300);                    // exact height only
		query(24'sd300, FLOOR_Y + 24'sd1, 24'sd300);
		drain();
		reg_write(REG_HEIGHT_WINDOW, 32'h7fffff);
		query(-24'sd300, COORD_MIN, 24'sd700);
		drain();

		// ---- random part ----
		for (int v = 0; v < MESH_VERTS; v++)
			vertex(SLOT_W'(v), near(51200), near(51200), near(51200));
		for (int f = 0; f < MESH_VERTS; f++)
			face(SLOT_W'(f), IDX_W'($urandom_range(0, MESH_VERTS - 1)),
				IDX_W'($urandom_range(0, MESH_VERTS - 1)),
				IDX_W'($urandom_range(0, MESH_VERTS - 1)));
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(REG_FACE_COUNT, (ph == 0) ? MESH_VERTS : $urandom_range(1, MESH_VERTS));
			case (ph)
				0: reg_write(REG_HEIGHT_WINDOW, 25600);
				1: reg_write(REG_HEIGHT_WINDOW, 32'h7fffff);
				2: reg_write(REG_HEIGHT_WINDOW, $urandom_range(0, 32'h7fffff));
				default: reg_write(REG_HEIGHT_WINDOW, $urandom_range(0, 60000));
			endcase
			steady = (ph == 1);
			if (ph == 2) begin
				// long receiver hold-off while queries keep coming: input backs up
				hold_req = 1'b1;
				for (int i = 0; i < 8; i++) query(near(51200), near(60000), near(51200));
			end
			random_phase(10, MESH_VERTS);
			drain();
		end
		steady = 1'b0;

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("mesh_height_query verification clean");
		else
			$display("mesh_height_query verification failed");
		$finish;
	end

endmodule
`default_nettype wire
